### rtl/pfb_pkg.sv
// shared constants, codes and controller/datapath struct types for the page framebuffer
package pfb_pkg;

    localparam int WIDTH_DEF  = 128;
    localparam int HEIGHT_DEF = 64;

    // item kinds
    localparam logic [2:0] KIND_FILL   = 3'd0;
    localparam logic [2:0] KIND_CURSOR = 3'd1;
    localparam logic [2:0] KIND_PIXEL  = 3'd2;
    localparam logic [2:0] KIND_GLYPH  = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_W = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_H = 2'd2;

    localparam logic [4:0] FONT_W_RST = 5'd7;
    localparam logic [5:0] FONT_H_RST = 6'd10;

    localparam logic [7:0] BYTE_ONES  = 8'hFF;
    localparam logic [7:0] BYTE_ZEROS = 8'h00;

    typedef struct packed {
        logic ld_item;
        logic sweep;
        logic pix_rd;
        logic pix_wr;
        logic gly_step;
        logic rd_issue;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       sweep_last;
        logic       pix_ok;
        logic       rd_ok;
        logic       gly_go;
        logic       gly_done;
        logic       out_free;
    } t_sts;

endpackage

### rtl/pfb_in_if.sv
// input item channel: valid/ready plus one command item
interface pfb_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        color;
    logic [15:0] glyph_bits;
    logic [4:0]  glyph_row;
    logic        last_row;

    modport source (output valid, kind, x, y, color, glyph_bits, glyph_row, last_row,
                    input ready);
    modport sink   (input valid, kind, x, y, color, glyph_bits, glyph_row, last_row,
                    output ready);
endinterface

### rtl/pfb_out_if.sv
// result item channel: valid/ready plus status, read byte and cursor
interface pfb_out_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [7:0] read_data;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;

    modport source (output valid, status, read_data, cursor_col, cursor_row, input ready);
    modport sink   (input valid, status, read_data, cursor_col, cursor_row, output ready);
endinterface

### rtl/page_framebuffer_text_renderer_unit.sv
// top level of the page framebuffer text renderer
//
//  port     | dir | content
//  i_item   | in  | kind, x, y, color, glyph_bits, glyph_row, last_row
//  o_res    | out | status, read_data, cursor_col, cursor_row
//  i_cfg_*  | in  | write enable, index, data (invert, font width, font height)
//
// cursor set, rejected items and unused kinds pass from accept through S_DISP and S_DONE to the result
// a pixel draw does one read-modify-write on the store port (S_PIX_RD, S_PIX_WR); a byte read uses S_RD
// a drawn glyph row writes font_width columns in S_GLY, one column per cycle
// fill sweeps all WIDTH*PAGES store bytes in S_FILL, one store byte per cycle
// after reset a clearing pass over all WIDTH*PAGES store bytes runs before the first item is taken
// a result waiting in the output register stalls only the next item's completion
module page_framebuffer_text_renderer_unit #(
    parameter int WIDTH  = pfb_pkg::WIDTH_DEF,
    parameter int HEIGHT = pfb_pkg::HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pfb_in_if.sink                         i_item,
    pfb_out_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [pfb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pfb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    pfb_pkg::t_cmd cmd;
    pfb_pkg::t_sts sts;
    logic          in_ready;

    assign i_item.ready = in_ready;

    pfb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_item.valid),
        .o_in_ready(in_ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    pfb_datapath #(
        .WIDTH (WIDTH),
        .HEIGHT(HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (i_item.kind),
        .i_x         (i_item.x),
        .i_y         (i_item.y),
        .i_color     (i_item.color),
        .i_glyph_bits(i_item.glyph_bits),
        .i_glyph_row (i_item.glyph_row),
        .i_last_row  (i_item.last_row),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_status    (o_res.status),
        .o_read_data (o_res.read_data),
        .o_cursor_col(o_res.cursor_col),
        .o_cursor_row(o_res.cursor_row)
    );
endmodule

### rtl/pfb_ram.sv
// generic simple dual-port ram, one write and one registered read port
module pfb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/pfb_datapath.sv
// datapath: item, config and cursor registers, frame store and result register
module pfb_datapath #(
    parameter int WIDTH  = pfb_pkg::WIDTH_DEF,
    parameter int HEIGHT = pfb_pkg::HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfb_pkg::t_cmd                 i_cmd,
    output pfb_pkg::t_sts                 o_sts,
    input  logic [2:0]                    i_kind,
    input  logic [7:0]                    i_x,
    input  logic [7:0]                    i_y,
    input  logic                          i_color,
    input  logic [15:0]                   i_glyph_bits,
    input  logic [4:0]                    i_glyph_row,
    input  logic                          i_last_row,
    input  logic                          i_cfg_we,
    input  logic [pfb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pfb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_status,
    output logic [7:0]                    o_read_data,
    output logic [7:0]                    o_cursor_col,
    output logic [7:0]                    o_cursor_row
);
    localparam int PAGES = (HEIGHT + 7) / 8;
    localparam int STORE = WIDTH * PAGES;
    localparam int AW    = $clog2(STORE);

    function automatic logic [7:0] set_bit(input logic [7:0] b, input logic [2:0] idx,
                                           input logic v);
        logic [7:0] res;
        res      = b;
        res[idx] = v;
        return res;
    endfunction

    // item registers
    logic [2:0]  r_kind;
    logic [7:0]  r_x, r_y;
    logic        r_color;
    logic [15:0] r_bits;
    logic [4:0]  r_grow;
    logic        r_last;
    // configuration and cursor
    logic        r_inv;
    logic [4:0]  r_fw;
    logic [5:0]  r_fh;
    logic [7:0]  r_ccol, r_crow;
    logic [7:0]  n_ccol, n_crow;
    // sweep and glyph column counters
    logic [AW-1:0] r_sw_addr;
    logic [4:0]    r_j, r_wcol;
    logic          r_wv;
    // result register
    logic          r_out_valid, r_o_status;
    logic [7:0]    r_o_rdata, r_o_ccol, r_o_crow;

    logic          pix_ok, rd_ok, fit_ok, gly_go, gly_issue, sweep_last;
    logic [8:0]    gly_line;
    logic [AW-1:0] pix_addr, rd_addr, gbase, gly_raddr, gly_waddr;
    logic          gly_on, gly_c, pix_c;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;
    logic          res_status;
    logic [7:0]    res_rdata;

    assign pix_ok = (9'(r_x) < 9'(WIDTH)) && (9'(r_y) < 9'(HEIGHT));
    assign rd_ok  = (9'(r_x) < 9'(WIDTH)) && (9'(r_y) < 9'(PAGES));
    assign fit_ok = ((9'(r_ccol) + 9'(r_fw)) < 9'(WIDTH)) &&
                    ((9'(r_crow) + 9'(r_fh)) < 9'(HEIGHT));
    assign gly_go = fit_ok && ({1'b0, r_grow} < r_fh);
    assign gly_issue  = r_j < r_fw;
    assign sweep_last = r_sw_addr == AW'(STORE - 1);

    assign gly_line  = 9'(r_crow) + 9'(r_grow);
    assign pix_addr  = AW'(r_x) + AW'(r_y[7:3]) * AW'(WIDTH);
    assign rd_addr   = AW'(r_x) + AW'(r_y) * AW'(WIDTH);
    assign gbase     = AW'(r_ccol) + AW'(gly_line[8:3]) * AW'(WIDTH);
    assign gly_raddr = gbase + AW'(r_j);
    assign gly_waddr = gbase + AW'(r_wcol);

    // columns past the sixteenth glyph bit paint background
    assign gly_on = !r_wcol[4] && r_bits[4'd15 - r_wcol[3:0]];
    assign gly_c  = (gly_on ? r_color : !r_color) ^ r_inv;
    assign pix_c  = r_color ^ r_inv;

    always_comb begin
        ram_we    = i_cmd.sweep || i_cmd.pix_wr || (i_cmd.gly_step && r_wv);
        ram_re    = i_cmd.pix_rd || i_cmd.rd_issue || (i_cmd.gly_step && gly_issue);
        ram_waddr = gly_waddr;
        ram_wdata = set_bit(ram_rdata, gly_line[2:0], gly_c);
        if (i_cmd.sweep) begin
            ram_waddr = r_sw_addr;
            ram_wdata = r_color ? pfb_pkg::BYTE_ONES : pfb_pkg::BYTE_ZEROS;
        end else if (i_cmd.pix_wr) begin
            ram_waddr = pix_addr;
            ram_wdata = set_bit(ram_rdata, r_y[2:0], pix_c);
        end
        ram_raddr = gly_raddr;
        if (i_cmd.pix_rd) begin
            ram_raddr = pix_addr;
        end else if (i_cmd.rd_issue) begin
            ram_raddr = rd_addr;
        end
    end

    pfb_ram #(
        .DATA_W(8),
        .DEPTH (STORE)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        res_status = 1'b1;
        res_rdata  = pfb_pkg::BYTE_ZEROS;
        n_ccol     = r_ccol;
        n_crow     = r_crow;
        case (r_kind)
            pfb_pkg::KIND_FILL: begin
                res_status = 1'b0;
            end
            pfb_pkg::KIND_CURSOR: begin
                res_status = 1'b0;
                n_ccol     = r_x;
                n_crow     = r_y;
            end
            pfb_pkg::KIND_PIXEL: begin
                res_status = !pix_ok;
            end
            pfb_pkg::KIND_GLYPH: begin
                res_status = !fit_ok;
                if (fit_ok && r_last) begin
                    n_ccol = r_ccol + 8'(r_fw);
                end
            end
            pfb_pkg::KIND_READ: begin
                res_status = !rd_ok;
                if (rd_ok) begin
                    res_rdata = ram_rdata;
                end
            end
            default: begin
                res_status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color     <= 1'b0;
            r_inv       <= 1'b0;
            r_fw        <= pfb_pkg::FONT_W_RST;
            r_fh        <= pfb_pkg::FONT_H_RST;
            r_ccol      <= '0;
            r_crow      <= '0;
            r_sw_addr   <= '0;
            r_j         <= '0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pfb_pkg::CFG_INVERT: r_inv <= i_cfg_data[0];
                    pfb_pkg::CFG_FONT_W: r_fw  <= i_cfg_data[4:0];
                    pfb_pkg::CFG_FONT_H: r_fh  <= i_cfg_data[5:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.ld_item) begin
                r_color <= i_color;
                r_j     <= '0;
                r_wv    <= 1'b0;
            end else if (i_cmd.gly_step) begin
                r_wv <= gly_issue;
                if (gly_issue) begin
                    r_j <= r_j + 5'd1;
                end
            end
            if (i_cmd.sweep) begin
                r_sw_addr <= sweep_last ? '0 : r_sw_addr + AW'(1);
            end
            if (i_cmd.load_out) begin
                r_ccol      <= n_ccol;
                r_crow      <= n_crow;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_kind <= i_kind;
            r_x    <= i_x;
            r_y    <= i_y;
            r_bits <= i_glyph_bits;
            r_grow <= i_glyph_row;
            r_last <= i_last_row;
        end
        if (i_cmd.gly_step) begin
            r_wcol <= r_j;
        end
        if (i_cmd.load_out) begin
            r_o_status <= res_status;
            r_o_rdata  <= res_rdata;
            r_o_ccol   <= n_ccol;
            r_o_crow   <= n_crow;
        end
    end

    assign o_sts.kind       = r_kind;
    assign o_sts.sweep_last = sweep_last;
    assign o_sts.pix_ok     = pix_ok;
    assign o_sts.rd_ok      = rd_ok;
    assign o_sts.gly_go     = gly_go;
    assign o_sts.gly_done   = !gly_issue && !r_wv;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_o_status;
    assign o_read_data  = r_o_rdata;
    assign o_cursor_col = r_o_ccol;
    assign o_cursor_row = r_o_crow;

    // a glyph read and write in the same cycle always hit different columns
    a_gly_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.gly_step && r_wv && gly_issue) |-> (gly_raddr != gly_waddr))
        else $error("glyph read and write collide");
endmodule

### rtl/pfb_ctrl.sv
// controller state machine sequencing fills, pixel and glyph writes and reads
module pfb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pfb_pkg::t_sts i_sts,
    output pfb_pkg::t_cmd o_cmd
);
    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_DISP   = 9'b000000100,
        S_FILL   = 9'b000001000,
        S_PIX_RD = 9'b000010000,
        S_PIX_WR = 9'b000100000,
        S_GLY    = 9'b001000000,
        S_RD     = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_item = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.kind)
                    pfb_pkg::KIND_FILL:  n_state = S_FILL;
                    pfb_pkg::KIND_PIXEL: n_state = i_sts.pix_ok ? S_PIX_RD : S_DONE;
                    pfb_pkg::KIND_GLYPH: n_state = i_sts.gly_go ? S_GLY : S_DONE;
                    pfb_pkg::KIND_READ:  n_state = i_sts.rd_ok ? S_RD : S_DONE;
                    default:             n_state = S_DONE;
                endcase
            end
            S_FILL: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_PIX_RD: begin
                o_cmd.pix_rd = 1'b1;
                n_state      = S_PIX_WR;
            end
            S_PIX_WR: begin
                o_cmd.pix_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_GLY: begin
                o_cmd.gly_step = 1'b1;
                if (i_sts.gly_done) begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DISP))
        else $error("accepted item not dispatched");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("item taken during clearing pass");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("result overwrites pending result");

    a_sweep_only_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sweep |-> (r_state == S_CLEAR || r_state == S_FILL))
        else $error("store sweep outside fill or clear");
endmodule
